### rtl/core/mco_pkg.sv
// Shared types, widths and helper functions for the mipmap chain offset block.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none
package mco_pkg;

    localparam int DIM_W   = 13;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int BYTE_W  = 27;
    localparam int Q_W     = 5;
    localparam int LVL_W   = 4;
    localparam int FMT_W   = 4;
    localparam int REQ_W   = 5;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT     = 2'd0;
    localparam logic [IDX_W-1:0] REG_BASE_WIDTH       = 2'd1;
    localparam logic [IDX_W-1:0] REG_BASE_HEIGHT      = 2'd2;
    localparam logic [IDX_W-1:0] REG_REQUESTED_LEVELS = 2'd3;

    localparam logic [FMT_W-1:0] FMT_L8      = 4'd0;
    localparam logic [FMT_W-1:0] FMT_L8A8    = 4'd1;
    localparam logic [FMT_W-1:0] FMT_RGB     = 4'd2;
    localparam logic [FMT_W-1:0] FMT_RGBA    = 4'd3;
    localparam logic [FMT_W-1:0] FMT_BGR     = 4'd4;
    localparam logic [FMT_W-1:0] FMT_BGRA    = 4'd5;
    localparam logic [FMT_W-1:0] FMT_YUV420P = 4'd6;
    localparam logic [FMT_W-1:0] FMT_CMP4    = 4'd7;
    localparam logic [FMT_W-1:0] FMT_CMP2    = 4'd8;
    localparam logic [FMT_W-1:0] FMT_CMP4A   = 4'd9;
    localparam logic [FMT_W-1:0] FMT_CMP2A   = 4'd10;

    typedef struct packed {
        logic init;
        logic step;
        logic fin;
        logic inv;
    } mco_ctl_t;

    function automatic logic [Q_W-1:0] quarter_bytes(input logic [FMT_W-1:0] fmt);
        logic [Q_W-1:0] q;
        case (fmt)
            FMT_L8:      q = 5'd4;
            FMT_L8A8:    q = 5'd8;
            FMT_RGB:     q = 5'd12;
            FMT_RGBA:    q = 5'd16;
            FMT_BGR:     q = 5'd12;
            FMT_BGRA:    q = 5'd16;
            FMT_YUV420P: q = 5'd6;
            FMT_CMP4:    q = 5'd2;
            FMT_CMP2:    q = 5'd1;
            FMT_CMP4A:   q = 5'd2;
            FMT_CMP2A:   q = 5'd1;
            default:     q = 5'd0;
        endcase
        return q;
    endfunction

    // Bytes of one level from its pixel count: ceil(pixels * q / 4).
    function automatic logic [BYTE_W-1:0] level_bytes(input logic [PROD_W-1:0] pix,
                                                      input logic [Q_W-1:0] q);
        logic [31:0] full;
        full = ({6'd0, pix} * {27'd0, q}) + 32'd3;
        return full[BYTE_W+1:2];
    endfunction

endpackage
`default_nettype wire

### rtl/core/mipmap_chain_offset.sv
// Top level of the mipmap chain offset block: configuration registers, level
// count and format checks, output register. Uses mco_pkg, mco_ctrl, mco_datapath.
//
// Configuration must be written through cfg_we, cfg_index and cfg_wdata only
// while the block is idle, which the block does not check: index 0 pixel format,
// 1 base width, 2 base height, 3 requested level count (two's complement,
// negative means all levels). Each word on the s_axis channel names one mip
// level. The block answers with one word on the m_axis channel carrying the
// level's byte offset, size in pixels, size in bytes and the effective level
// count; tuser carries the level-invalid and config-invalid flags.
// A query for level L steps through levels 0 to L, one per cycle, in the shared
// width-by-height multiplier and offset adder, and then finishes. A level above
// the count skips the steps and goes straight to the finish. s_axis_tready is
// high only while the sequencer is idle, so the next query is taken in the
// cycle after the finish at the earliest.
// The result waits in an output register; a new query is taken while it
// waits, but finishes only once the receiver takes the old result.
// Reset clears all handshakes and loads the register defaults.
`default_nettype none
module mipmap_chain_offset #(
    parameter int MAX_DIM_LOG2 = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // level[3:0], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // byte_offset[26:0], level_width[39:27], level_height[52:40],
    // level_bytes[79:53], level_count[83:80], zero pad
    output logic [87:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser   // level_invalid[0], config_invalid[1]
);

    localparam longint DIM_LIM = 64'd1 << MAX_DIM_LOG2;

    logic [mco_pkg::FMT_W-1:0] fmt_reg;
    logic [mco_pkg::DIM_W-1:0] bw_reg, bh_reg;
    logic [mco_pkg::REQ_W-1:0] req_reg;

    logic [mco_pkg::DIM_W-1:0] eff_w, eff_h, wh_or;
    logic [mco_pkg::LVL_W-1:0] maxlev, count;
    logic                      cfg_bad;
    logic [mco_pkg::Q_W-1:0]   q;

    mco_pkg::mco_ctl_t          ctl;
    logic [mco_pkg::BYTE_W-1:0] dp_off, dp_bytes;
    logic [mco_pkg::DIM_W-1:0]  dp_w, dp_h;

    logic                       ovalid_reg;
    logic [mco_pkg::BYTE_W-1:0] o_off_reg, o_bytes_reg;
    logic [mco_pkg::DIM_W-1:0]  o_w_reg, o_h_reg;
    logic [mco_pkg::LVL_W-1:0]  o_cnt_reg;
    logic                       o_linv_reg, o_cinv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= mco_pkg::FMT_L8;
            bw_reg  <= 13'd1;
            bh_reg  <= 13'd1;
            req_reg <= 5'h1F;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mco_pkg::REG_PIXEL_FORMAT:     fmt_reg <= cfg_wdata[3:0];
                mco_pkg::REG_BASE_WIDTH:       bw_reg  <= cfg_wdata;
                mco_pkg::REG_BASE_HEIGHT:      bh_reg  <= cfg_wdata;
                mco_pkg::REG_REQUESTED_LEVELS: req_reg <= cfg_wdata[4:0];
                default:                       fmt_reg <= fmt_reg;
            endcase
        end
    end

    always_comb
    begin
        if (bw_reg == '0)
            eff_w = 13'd1;
        else if (64'(bw_reg) > DIM_LIM)
            eff_w = mco_pkg::DIM_W'(DIM_LIM);
        else
            eff_w = bw_reg;
        if (bh_reg == '0)
            eff_h = 13'd1;
        else if (64'(bh_reg) > DIM_LIM)
            eff_h = mco_pkg::DIM_W'(DIM_LIM);
        else
            eff_h = bh_reg;
    end

    assign wh_or = eff_w | eff_h;

    always_comb
    begin
        maxlev = '0;
        for (int i = 0; i < mco_pkg::DIM_W; i++)
        begin
            if (wh_or[i])
                maxlev = mco_pkg::LVL_W'(i);
        end
    end

    always_comb
    begin
        if (req_reg[4])
            count = maxlev;
        else if (req_reg[3:0] > maxlev)
            count = maxlev;
        else
            count = req_reg[3:0];
    end

    assign cfg_bad = (fmt_reg == mco_pkg::FMT_YUV420P) &&
                     (eff_w[0] || eff_h[0] || (eff_w < 13'd4) || (eff_h < 13'd4));
    assign q = mco_pkg::quarter_bytes(fmt_reg);

    mco_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .level    (s_axis_tdata[3:0]),
        .count    (count),
        .out_busy (ovalid_reg && !m_axis_tready),
        .in_ready (s_axis_tready),
        .ctl      (ctl)
    );

    mco_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .dim_w     (eff_w),
        .dim_h     (eff_h),
        .q         (q),
        .offset    (dp_off),
        .lvl_w     (dp_w),
        .lvl_h     (dp_h),
        .lvl_bytes (dp_bytes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (ctl.fin)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin)
        begin
            o_off_reg   <= ctl.inv ? '0 : dp_off;
            o_w_reg     <= ctl.inv ? '0 : dp_w;
            o_h_reg     <= ctl.inv ? '0 : dp_h;
            o_bytes_reg <= ctl.inv ? '0 : dp_bytes;
            o_cnt_reg   <= count;
            o_linv_reg  <= ctl.inv;
            o_cinv_reg  <= cfg_bad;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, o_cnt_reg, o_bytes_reg, o_h_reg, o_w_reg, o_off_reg};
    assign m_axis_tuser  = {o_cinv_reg, o_linv_reg};

endmodule
`default_nettype wire

### rtl/core/mco_ctrl.sv
// Sequencer of the mipmap chain offset block: walks the levels one per cycle.
// Depends on mco_pkg.
`default_nettype none
module mco_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [mco_pkg::LVL_W-1:0] level,
    input  wire logic [mco_pkg::LVL_W-1:0] count,
    input  wire logic                      out_busy,
    output logic                           in_ready,
    output mco_pkg::mco_ctl_t              ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [mco_pkg::LVL_W-1:0]  idx_reg, idx_next;
    logic [mco_pkg::LVL_W-1:0]  level_reg, level_next;
    logic                       inv_reg, inv_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        level_next = level_reg;
        inv_next   = inv_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        ctl.inv    = inv_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.init   = 1'b1;
                    idx_next   = '0;
                    level_next = level;
                    inv_next   = (level > count);
                    state_next = (level > count) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
                idx_next = idx_reg + 4'd1;
                if (idx_reg == level_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!out_busy)
                begin
                    ctl.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            level_reg <= '0;
            inv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            level_reg <= level_next;
            inv_reg   <= inv_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/mco_datapath.sv
// Shared multiply and accumulate unit: one level's pixel count per step,
// its bytes added to the offset on the next step. Depends on mco_pkg.
`default_nettype none
module mco_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mco_pkg::mco_ctl_t          ctl,
    input  wire logic [mco_pkg::DIM_W-1:0]  dim_w,
    input  wire logic [mco_pkg::DIM_W-1:0]  dim_h,
    input  wire logic [mco_pkg::Q_W-1:0]    q,
    output logic [mco_pkg::BYTE_W-1:0]      offset,
    output logic [mco_pkg::DIM_W-1:0]       lvl_w,
    output logic [mco_pkg::DIM_W-1:0]       lvl_h,
    output logic [mco_pkg::BYTE_W-1:0]      lvl_bytes
);

    logic [mco_pkg::DIM_W-1:0]  cw_reg, ch_reg;
    logic [mco_pkg::DIM_W-1:0]  pw_reg, ph_reg;
    logic [mco_pkg::PROD_W-1:0] prod_reg;
    logic [mco_pkg::BYTE_W-1:0] off_reg;
    logic                       pv_reg;
    logic [mco_pkg::BYTE_W-1:0] prev_bytes;

    assign prev_bytes = mco_pkg::level_bytes(prod_reg, q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (ctl.init)
        begin
            pv_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            pv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            cw_reg  <= dim_w;
            ch_reg  <= dim_h;
            off_reg <= '0;
        end
        else if (ctl.step)
        begin
            prod_reg <= {{mco_pkg::DIM_W{1'b0}}, cw_reg} * {{mco_pkg::DIM_W{1'b0}}, ch_reg};
            pw_reg   <= cw_reg;
            ph_reg   <= ch_reg;
            cw_reg   <= (cw_reg == 13'd1) ? cw_reg : (cw_reg >> 1);
            ch_reg   <= (ch_reg == 13'd1) ? ch_reg : (ch_reg >> 1);
            if (pv_reg)
            begin
                off_reg <= off_reg + prev_bytes;
            end
        end
    end

    assign offset    = off_reg;
    assign lvl_w     = pw_reg;
    assign lvl_h     = ph_reg;
    assign lvl_bytes = prev_bytes;

endmodule
`default_nettype wire

### test/tb_mipmap_chain_offset.sv
`timescale 1ns / 100ps
// Self-checking testbench for mipmap_chain_offset: directed table, then random phases.
// Expected: typed rows or the predictor below; depends on mco_pkg and the RTL.
module tb_mipmap_chain_offset;

    localparam int MAX_LOG2      = 12;
    localparam int DIM_MAX       = 1 << MAX_LOG2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_QUERIES = 95;
    localparam int DIR_ROWS      = 24;
    localparam int DRAIN_CYCLES  = 25;

    localparam logic [4:0] REQ_ALL      = 5'h1F;
    localparam logic [4:0] REQ_MOST_NEG = 5'h10;

    localparam logic [mco_pkg::FMT_W-1:0] FMT_UNKNOWN_LO = 4'd11;
    localparam logic [mco_pkg::FMT_W-1:0] FMT_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [26:0] byte_offset;
        logic [12:0] width;
        logic [12:0] height;
        logic [26:0] bytes;
        logic [3:0]  count;
        logic        level_inv;
        logic        cfg_inv;
    } placement_t;

    typedef struct packed {
        logic [3:0]  fmt;
        logic [12:0] w;
        logic [12:0] h;
        logic [4:0]  req;
        logic [3:0]  lvl;
        logic        typed;
        placement_t  want;
    } query_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [3:0]  cur_fmt = mco_pkg::FMT_L8;
    logic [12:0] cur_w = 13'd1;
    logic [12:0] cur_h = 13'd1;
    logic [4:0]  cur_req = REQ_ALL;

    placement_t  placement_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    query_row_t dir_rows [DIR_ROWS] = '{
        '{mco_pkg::FMT_L8,      13'd1,    13'd1,    REQ_ALL,      4'd0,  1'b1,
          '{27'd0, 13'd1, 13'd1, 27'd1, 4'd0, 1'b0, 1'b0}},
        '{mco_pkg::FMT_L8,      13'd1,    13'd1,    REQ_ALL,      4'd15, 1'b1,
          '{27'd0, 13'd0, 13'd0, 27'd0, 4'd0, 1'b1, 1'b0}},
        '{mco_pkg::FMT_RGBA,    13'd4096, 13'd4096, REQ_ALL,      4'd0,  1'b1,
          '{27'd0, 13'd4096, 13'd4096, 27'd67108864, 4'd12, 1'b0, 1'b0}},
        '{mco_pkg::FMT_RGBA,    13'd4096, 13'd4096, REQ_ALL,      4'd12, 1'b0, '0},
        '{mco_pkg::FMT_RGBA,    13'd4096, 13'd4096, REQ_ALL,      4'd13, 1'b1,
          '{27'd0, 13'd0, 13'd0, 27'd0, 4'd12, 1'b1, 1'b0}},
        '{mco_pkg::FMT_RGBA,    13'd8191, 13'd0,    REQ_ALL,      4'd0,  1'b1,
          '{27'd0, 13'd4096, 13'd1, 27'd16384, 4'd12, 1'b0, 1'b0}},
        '{mco_pkg::FMT_RGBA,    13'd8191, 13'd0,    REQ_ALL,      4'd12, 1'b0, '0},
        '{mco_pkg::FMT_L8A8,    13'd0,    13'd8191, 5'd0,         4'd0,  1'b1,
          '{27'd0, 13'd1, 13'd4096, 27'd8192, 4'd0, 1'b0, 1'b0}},
        '{mco_pkg::FMT_L8A8,    13'd0,    13'd8191, 5'd0,         4'd1,  1'b1,
          '{27'd0, 13'd0, 13'd0, 27'd0, 4'd0, 1'b1, 1'b0}},
        '{mco_pkg::FMT_RGB,     13'd640,  13'd480,  5'd3,         4'd3,  1'b0, '0},
        '{mco_pkg::FMT_RGB,     13'd640,  13'd480,  5'd3,         4'd4,  1'b1,
          '{27'd0, 13'd0, 13'd0, 27'd0, 4'd3, 1'b1, 1'b0}},
        '{mco_pkg::FMT_BGR,     13'd100,  13'd75,   5'd12,        4'd6,  1'b0, '0},
        '{mco_pkg::FMT_BGRA,    13'd33,   13'd17,   5'd15,        4'd5,  1'b0, '0},
        '{mco_pkg::FMT_YUV420P, 13'd6,    13'd8,    REQ_ALL,      4'd0,  1'b1,
          '{27'd0, 13'd6, 13'd8, 27'd72, 4'd3, 1'b0, 1'b0}},
        '{mco_pkg::FMT_YUV420P, 13'd3,    13'd8,    REQ_ALL,      4'd1,  1'b0, '0},
        '{mco_pkg::FMT_YUV420P, 13'd2,    13'd2,    REQ_ALL,      4'd0,  1'b1,
          '{27'd0, 13'd2, 13'd2, 27'd6, 4'd1, 1'b0, 1'b1}},
        '{mco_pkg::FMT_CMP4,    13'd512,  13'd512,  REQ_MOST_NEG, 4'd9,  1'b0, '0},
        '{mco_pkg::FMT_CMP2,    13'd7,    13'd3,    5'd2,         4'd2,  1'b0, '0},
        '{mco_pkg::FMT_CMP4A,   13'd256,  13'd64,   REQ_ALL,      4'd8,  1'b0, '0},
        '{mco_pkg::FMT_CMP2A,   13'd1,    13'd1,    REQ_ALL,      4'd0,  1'b1,
          '{27'd0, 13'd1, 13'd1, 27'd1, 4'd0, 1'b0, 1'b0}},
        '{FMT_UNKNOWN_LO,       13'd64,   13'd64,   REQ_ALL,      4'd3,  1'b1,
          '{27'd0, 13'd8, 13'd8, 27'd0, 4'd6, 1'b0, 1'b0}},
        '{FMT_UNKNOWN_HI,       13'd4096, 13'd4096, 5'd12,        4'd12, 1'b1,
          '{27'd0, 13'd1, 13'd1, 27'd0, 4'd12, 1'b0, 1'b0}},
        '{mco_pkg::FMT_L8,      13'd4097, 13'd2,    REQ_ALL,      4'd12, 1'b0, '0},
        '{mco_pkg::FMT_YUV420P, 13'd8191, 13'd8191, REQ_ALL,      4'd0,  1'b0, '0}
    };

    mipmap_chain_offset #(
        .MAX_DIM_LOG2(MAX_LOG2)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic int unsigned limit_dim(input logic [12:0] d);
        if (d == 13'd0)
            return 1;
        if (d > DIM_MAX)
            return DIM_MAX;
        return d;
    endfunction

    function automatic int unsigned pixel_quarters(input logic [3:0] fmt);
        case (fmt)
            mco_pkg::FMT_L8:      return 4;
            mco_pkg::FMT_L8A8:    return 8;
            mco_pkg::FMT_RGB:     return 12;
            mco_pkg::FMT_RGBA:    return 16;
            mco_pkg::FMT_BGR:     return 12;
            mco_pkg::FMT_BGRA:    return 16;
            mco_pkg::FMT_YUV420P: return 6;
            mco_pkg::FMT_CMP4:    return 2;
            mco_pkg::FMT_CMP2:    return 1;
            mco_pkg::FMT_CMP4A:   return 2;
            mco_pkg::FMT_CMP2A:   return 1;
            default:              return 0;
        endcase
    endfunction

    function automatic placement_t predict_placement(input logic [3:0] lvl);
        int unsigned     w, h, tw, th, q, maxlev, cnt, i;
        longint unsigned off, sz;
        placement_t      p;
        w = limit_dim(cur_w);
        h = limit_dim(cur_h);
        q = pixel_quarters(cur_fmt);
        tw = w;
        th = h;
        maxlev = 0;
        while ((tw >> 1) != 0 || (th >> 1) != 0)
        begin
            tw = tw >> 1;
            th = th >> 1;
            maxlev++;
        end
        if (cur_req[4])
            cnt = maxlev;
        else
            cnt = (cur_req > maxlev) ? maxlev : cur_req;
        p = '0;
        p.count = cnt[3:0];
        p.cfg_inv = (cur_fmt == mco_pkg::FMT_YUV420P) && (w[0] || h[0] || w < 4 || h < 4);
        if (lvl > cnt)
        begin
            p.level_inv = 1'b1;
            return p;
        end
        off = 0;
        for (i = 0; i < lvl; i++)
        begin
            off += (longint'(w) * h * q + 3) >> 2;
            w = (w == 1) ? 1 : (w >> 1);
            h = (h == 1) ? 1 : (h >> 1);
        end
        sz = (longint'(w) * h * q + 3) >> 2;
        p.byte_offset = off[26:0];
        p.width = w[12:0];
        p.height = h[12:0];
        p.bytes = sz[26:0];
        return p;
    endfunction

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(0, 5))
            0:       return 13'd1;
            1:       return 13'(DIM_MAX);
            2:       return 13'($urandom);
            3:       return 13'($urandom_range(0, 64));
            4:       return 13'(1 << $urandom_range(0, MAX_LOG2));
            default: return 13'($urandom_range(1, DIM_MAX));
        endcase
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    task automatic wait_chain_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (placement_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [3:0] fmt, input logic [12:0] w,
                                input logic [12:0] h, input logic [4:0] req);
        wait_chain_idle();
        cfg_we <= 1'b1;
        cfg_index <= mco_pkg::REG_PIXEL_FORMAT;
        cfg_wdata <= {9'd0, fmt};
        @(posedge clk);
        cfg_index <= mco_pkg::REG_BASE_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_index <= mco_pkg::REG_BASE_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_index <= mco_pkg::REG_REQUESTED_LEVELS;
        cfg_wdata <= {8'd0, req};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_fmt = fmt;
        cur_w = w;
        cur_h = h;
        cur_req = req;
    endtask

    task automatic query_level(input logic [3:0] lvl, input logic typed,
                               input placement_t want);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, lvl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        placement_q.push_back(typed ? want : predict_placement(lvl));
    endtask

    initial
    begin
        placement_t want;
        placement_t got;
        int         gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_wait();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got.byte_offset = m_axis_tdata[26:0];
            got.width = m_axis_tdata[39:27];
            got.height = m_axis_tdata[52:40];
            got.bytes = m_axis_tdata[79:53];
            got.count = m_axis_tdata[83:80];
            got.level_inv = m_axis_tuser[0];
            got.cfg_inv = m_axis_tuser[1];
            if (placement_q.size() == 0)
            begin
                $error("result word arrived with no placement expected");
                mismatch_count++;
            end
            else
            begin
                want = placement_q.pop_front();
                check_field("byte_offset", want.byte_offset, got.byte_offset);
                check_field("level_width", want.width, got.width);
                check_field("level_height", want.height, got.height);
                check_field("level_bytes", want.bytes, got.bytes);
                check_field("level_count", want.count, got.count);
                check_field("level_invalid", want.level_inv, got.level_inv);
                check_field("config_invalid", want.cfg_inv, got.cfg_inv);
            end
        end
    end

    initial
    begin
        query_row_t  row;
        placement_t  probe;
        logic [3:0]  fmt;
        logic [12:0] w;
        logic [12:0] h;
        logic [4:0]  req;
        logic [3:0]  lvl;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            if (row.fmt != cur_fmt || row.w != cur_w || row.h != cur_h || row.req != cur_req)
                program_regs(row.fmt, row.w, row.h, row.req);
            query_level(row.lvl, row.typed, row.want);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            steady = (phase % 5 == 2);
            fmt = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 10)) : 4'($urandom);
            w = pick_dim();
            h = pick_dim();
            if (fmt == mco_pkg::FMT_YUV420P && $urandom_range(0, 2) != 0)
            begin
                w = {w[12:1], 1'b0};
                h = {h[12:1], 1'b0};
                if (w < 4)
                    w = 13'd4;
                if (h < 4)
                    h = 13'd4;
            end
            case ($urandom_range(0, 3))
                0:       req = REQ_ALL;
                1:       req = 5'($urandom);
                default: req = 5'($urandom_range(0, MAX_LOG2));
            endcase
            program_regs(fmt, w, h, req);
            probe = predict_placement(4'd0);
            repeat (PHASE_QUERIES)
            begin
                if ($urandom_range(0, 4) != 0)
                    lvl = 4'($urandom_range(0, probe.count));
                else
                    lvl = 4'($urandom);
                query_level(lvl, 1'b0, '0);
            end
        end

        wait_chain_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
